### hdl/gaussian_source_term_sum_macros.svh
// assertion macros for the gaussian source term sum checker
`ifndef GAUSSIAN_SOURCE_TERM_SUM_MACROS_SVH
`define GAUSSIAN_SOURCE_TERM_SUM_MACROS_SVH

// same-cycle implication, masked while reset is high
`define GSTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsts checker: same-cycle property failed");

// next-cycle implication, checked through reset as well
`define GSTS_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gsts checker: next-cycle property failed");

`endif

### hdl/gsts_pkg.sv
// shared types, constants and exp table for the gaussian source term sum
package gsts_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] REG_DIMENSION    = 2'd0;
  localparam logic [1:0] REG_SOURCE_COUNT = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int EXP_TABLE_SIZE = 256;
  localparam int TAB_W          = $clog2(EXP_TABLE_SIZE);

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q31   = 64'd1488522236;
  localparam logic [21:0] P_CLAMP   = 22'h200000;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] amp;
    logic [31:0] dec;
  } source_t;

  typedef struct packed {
    logic        is_eval;
    logic        load_ok;
    logic [5:0]  slot;
    source_t     src;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_out_t;

  typedef struct packed {
    logic        valid;
    source_t     src;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic [1:0]  dim;
  } term_in_t;

  typedef struct packed {
    logic        valid;
    logic        busy;
    logic [63:0] t;
    logic        sat;
  } term_out_t;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_SIZE+1];

  // 2^(-i/size) in q2.30 from a q1.31 taylor series of exp(-i*ln2/size)
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] acc;
    for (int i = 0; i <= EXP_TABLE_SIZE; i++) begin
      t    = (64'(i) * LN2_Q31) / EXP_TABLE_SIZE;
      term = 64'd1 << 31;
      acc  = term;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          term = ((term * t) >> 31) / 64'(n);
          if (n[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
      tab[i] = 32'((acc + 64'd1) >> 1);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

### hdl/gsts_front.sv
// command front end: classification and command queue
module gsts_front #(
  parameter int MAX_SOURCES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  logic [5:0]          slot,
  input  logic [31:0]         coord_x,
  input  logic [31:0]         coord_y,
  input  logic [31:0]         coord_z,
  input  logic [31:0]         amplitude,
  input  logic [31:0]         decay,
  input  logic                pop,
  output logic                busy,
  output gsts_pkg::queue_out_t head
);

  gsts_pkg::queue_entry_t entries [gsts_pkg::QUEUE_DEPTH];
  gsts_pkg::queue_entry_t new_entry;
  logic [gsts_pkg::QPTR_W-1:0] wr_ptr;
  logic [gsts_pkg::QPTR_W-1:0] rd_ptr;
  logic [gsts_pkg::QPTR_W:0]   count;
  logic push;
  logic do_pop;

  always_comb begin
    new_entry.is_eval = (command == gsts_pkg::CMD_EVAL);
    new_entry.load_ok = (32'(slot) < 32'(MAX_SOURCES));
    new_entry.slot    = slot;
    new_entry.src.cx  = coord_x;
    new_entry.src.cy  = coord_y;
    new_entry.src.cz  = coord_z;
    new_entry.src.amp = amplitude;
    new_entry.src.dec = decay;
  end

  assign busy       = (count == (gsts_pkg::QPTR_W+1)'(gsts_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/gsts_term.sv
// pipelined evaluation of one source term per cycle
module gsts_term (
  input  logic                 clk,
  input  logic                 rst,
  input  gsts_pkg::term_in_t   in,
  output gsts_pkg::term_out_t  out
);

  localparam int STAGES    = 14;
  localparam int TAB_IDX_W = gsts_pkg::TAB_W + 1;

  typedef struct packed {
    logic [31:0] dec;
    logic [31:0] amag;
    logic        aneg;
    logic [1:0]  dim;
  } side_t;

  logic  [STAGES:1] v;
  side_t side [STAGES:1];

  // stage 1 distances
  logic [32:0] dxs, dys, dzs;
  logic [31:0] mx, my, mz;
  // stage 2 squares
  logic [63:0] sqx, sqy, sqz;
  // stage 3 and 4 saturating sums
  logic [64:0] sum_a, sum_b;
  logic [63:0] d2a, sqz3, d2;
  // stage 5 and 6 decay product
  logic [63:0] bh, bl;
  logic [64:0] psum;
  logic [21:0] p;
  // stage 7 base-two reduction
  logic [52:0] y;
  logic [25:0] pow2, p4;
  logic [23:0] gm7;
  logic [23:0] gm7_next;
  logic        gneg7;
  // gm held until the scaled exp multiply
  logic [23:0] gm8, gm9, gm10;
  // stage 8 table
  logic [31:0]       fr;
  logic [TAB_IDX_W-1:0] idx0, idx1;
  logic [31:0] e0_8, ediff8, rem8;
  logic [6:0]  k8;
  // stage 9 interpolation
  logic [63:0] iprod;
  logic [31:0] e0_9;
  logic [6:0]  k9;
  // stage 10 exp and amplitude product
  logic [31:0] v10;
  logic [31:0] e10;
  logic [63:0] ab10;
  // stage 11 scaled exp
  logic [55:0] eg;
  logic [39:0] m30;
  logic [63:0] ab11;
  // stage 12 partial products
  logic [71:0] pp0, pp1;
  // stage 13 wide magnitude
  logic [103:0] full;
  logic [63:0]  mag;
  // stage 14 clip
  logic [63:0] t14;
  logic        sat14;
  logic [63:0] t_next;
  logic        sat_next;
  // sign of g carried from stage 7
  logic [STAGES:7] gneg;

  assign dxs = {in.qx[31], in.qx} - {in.src.cx[31], in.src.cx};
  assign dys = {in.qy[31], in.qy} - {in.src.cy[31], in.src.cy};
  assign dzs = {in.qz[31], in.qz} - {in.src.cz[31], in.src.cz};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[STAGES-1:1], in.valid};
    end
  end

  always_ff @(posedge clk) begin
    side[1].dec  <= in.src.dec;
    side[1].aneg <= in.src.amp[31];
    side[1].amag <= in.src.amp[31] ? 32'(-in.src.amp) : in.src.amp;
    side[1].dim  <= in.dim;
    for (int i = 2; i <= STAGES; i++) begin
      side[i] <= side[i-1];
    end
    gneg[7] <= gneg7;
    for (int i = 8; i <= STAGES; i++) begin
      gneg[i] <= gneg[i-1];
    end
  end

  always_ff @(posedge clk) begin
    mx <= dxs[32] ? 32'(-dxs) : dxs[31:0];
    my <= (in.dim >= 2'd2) ? (dys[32] ? 32'(-dys) : dys[31:0]) : 32'd0;
    mz <= (in.dim == 2'd3) ? (dzs[32] ? 32'(-dzs) : dzs[31:0]) : 32'd0;
    sqx <= 64'(mx) * 64'(mx);
    sqy <= 64'(my) * 64'(my);
    sqz <= 64'(mz) * 64'(mz);
    d2a  <= sum_a[64] ? '1 : sum_a[63:0];
    sqz3 <= sqz;
    d2   <= sum_b[64] ? '1 : sum_b[63:0];
    bh <= 64'(side[4].dec) * 64'(d2[63:32]);
    bl <= 64'(side[4].dec) * 64'(d2[31:0]);
    p  <= (psum > 65'(gsts_pkg::P_CLAMP)) ? gsts_pkg::P_CLAMP : psum[21:0];
    y     <= 53'(p) * 53'(gsts_pkg::LOG2E_Q30);
    gm7   <= gm7_next;
    e0_8   <= gsts_pkg::EXP_TAB[idx0];
    ediff8 <= gsts_pkg::EXP_TAB[idx0] - gsts_pkg::EXP_TAB[idx1];
    rem8   <= {fr[31-gsts_pkg::TAB_W:0], gsts_pkg::TAB_W'(0)};
    k8     <= y[52:46];
    iprod <= 64'(ediff8) * 64'(rem8);
    e0_9  <= e0_8;
    k9    <= k8;
    e10  <= (k9 >= 7'd32) ? 32'd0 : (v10 >> k9[4:0]);
    ab10 <= 64'(side[9].amag) * 64'(side[9].dec);
    eg   <= 56'(e10) * 56'(gm10);
    ab11 <= ab10;
    pp0 <= 72'(ab11[31:0]) * 72'(m30);
    pp1 <= 72'(ab11[63:32]) * 72'(m30);
    full <= 104'(pp0) + (104'(pp1) << 32);
    t14   <= t_next;
    sat14 <= sat_next;
  end

  assign sum_a = 65'(sqx) + 65'(sqy);
  assign sum_b = 65'(d2a) + 65'(sqz3);
  assign psum  = 65'(bh) + 65'(bl[63:32]);

  assign pow2  = 26'd1 << (5'd16 + 5'(side[6].dim));
  assign p4    = {2'b00, p, 2'b00};
  assign gneg7 = (p4 > pow2);
  assign gm7_next = gneg7 ? 24'(p4 - pow2) : 24'(pow2 - p4);

  always_ff @(posedge clk) begin
    gm8  <= gm7;
    gm9  <= gm8;
    gm10 <= gm9;
  end

  assign fr   = y[45:14];
  assign idx0 = TAB_IDX_W'(fr[31 -: gsts_pkg::TAB_W]);
  assign idx1 = idx0 + 1'b1;

  assign v10 = e0_9 - iprod[63:32];
  assign m30 = eg[55:16];
  assign mag = (|full[103:94]) ? '1 : full[93:30];

  always_comb begin
    t_next   = mag;
    sat_next = 1'b0;
    if (side[13].aneg ^ gneg[13]) begin
      if (mag > 64'h8000_0000_0000_0000) begin
        t_next   = 64'h8000_0000_0000_0000;
        sat_next = 1'b1;
      end else begin
        t_next = -mag;
      end
    end else if (mag[63]) begin
      t_next   = 64'h7fff_ffff_ffff_ffff;
      sat_next = 1'b1;
    end
  end

  assign out.valid = v[STAGES];
  assign out.busy  = |v;
  assign out.t     = t14;
  assign out.sat   = sat14;

endmodule

### hdl/gsts_back.sv
// command back end: source store, walk sequencer and accumulator
module gsts_back #(
  parameter int MAX_SOURCES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gsts_pkg::queue_out_t head,
  input  logic [1:0]           dimension,
  input  logic [6:0]           source_count,
  output logic                 pop,
  output logic                 done,
  output logic [63:0]          total,
  output logic                 saturated
);

  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  gsts_pkg::source_t mem [MAX_SOURCES];
  gsts_pkg::source_t rd_data;
  logic              rd_v;
  logic              issue;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      qx, qy, qz;
  logic [1:0]       dim;
  logic [63:0]      acc;
  logic             acc_sat;
  logic [63:0]      acc_sum;
  logic             acc_ovf;

  gsts_pkg::term_in_t  term_in;
  gsts_pkg::term_out_t term_out;

  assign cnt = (CNT_W'(source_count) > CNT_W'(MAX_SOURCES)) ?
               CNT_W'(MAX_SOURCES) : CNT_W'(source_count);

  assign pop     = (state == ST_IDLE) && head.valid;
  assign mem_we  = pop && !head.entry.is_eval && head.entry.load_ok;
  assign wr_addr = IDX_W'(head.entry.slot);
  assign issue   = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= head.entry.src;
    end
    rd_data <= mem[idx[IDX_W-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && head.entry.is_eval) begin
          state_next = (cnt == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (CNT_W'(idx + 1'b1) == cnt) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v && !term_out.busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      done  <= (state == ST_DRAIN) && (state_next == ST_IDLE);
    end
  end

  // query latch and walk index
  always_ff @(posedge clk) begin
    if (pop && head.entry.is_eval) begin
      qx  <= head.entry.src.cx;
      qy  <= head.entry.src.cy;
      qz  <= head.entry.src.cz;
      dim <= (dimension == 2'd0) ? 2'd1 : dimension;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
  end

  assign term_in.valid = rd_v;
  assign term_in.src   = rd_data;
  assign term_in.qx    = qx;
  assign term_in.qy    = qy;
  assign term_in.qz    = qz;
  assign term_in.dim   = dim;

  gsts_term u_term (
    .clk (clk),
    .rst (rst),
    .in  (term_in),
    .out (term_out)
  );

  assign acc_sum = acc + term_out.t;
  assign acc_ovf = (acc[63] == term_out.t[63]) && (acc_sum[63] != acc[63]);

  always_ff @(posedge clk) begin
    if (pop && head.entry.is_eval) begin
      acc     <= '0;
      acc_sat <= 1'b0;
    end else if (term_out.valid) begin
      if (acc_ovf) begin
        acc <= term_out.t[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      end else begin
        acc <= acc_sum;
      end
      acc_sat <= acc_sat | acc_ovf | term_out.sat;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DRAIN) && (state_next == ST_IDLE)) begin
      total     <= acc;
      saturated <= acc_sat;
    end
  end

endmodule

### hdl/gaussian_source_term_sum.sv
// Gaussian source term sum: commands are queued four deep; busy is high only
// while that queue is full. A load leaves the queue and writes one slot of
// the source store if slot is below MAX_SOURCES. An evaluate walks the first
// source_count sources (at most MAX_SOURCES), one source per cycle into a
// fourteen-stage term pipeline fed by a registered store read. The result is
// written to total and saturated, where it stays until the next evaluate
// ends, and is marked by done; it cannot be held off.
// Slots never loaded read as undefined.
module gaussian_source_term_sum #(
  parameter int MAX_SOURCES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [5:0]  slot,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [31:0] amplitude,
  input  logic [31:0] decay,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [6:0]  wr_data,
  output logic        done,
  output logic [63:0] total,
  output logic        saturated
);

  logic [1:0] dimension;
  logic [6:0] source_count;
  logic       pop;
  gsts_pkg::queue_out_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension    <= 2'd1;
      source_count <= 7'd0;
    end else if (wr_en) begin
      case (wr_index)
        gsts_pkg::REG_DIMENSION:    dimension    <= wr_data[1:0];
        gsts_pkg::REG_SOURCE_COUNT: source_count <= wr_data;
        default: ;
      endcase
    end
  end

  gsts_front #(.MAX_SOURCES(MAX_SOURCES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .slot      (slot),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .amplitude (amplitude),
    .decay     (decay),
    .pop       (pop),
    .busy      (busy),
    .head      (head)
  );

  gsts_back #(.MAX_SOURCES(MAX_SOURCES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .dimension    (dimension),
    .source_count (source_count),
    .pop          (pop),
    .done         (done),
    .total        (total),
    .saturated    (saturated)
  );

endmodule

### hdl/gsts_checker.sv
// port-level checks for the gaussian source term sum
`include "gaussian_source_term_sum_macros.svh"

module gsts_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done
);

  `GSTS_ASSERT_NEXT(a_no_done_after_reset, clk, rst, !done)
  `GSTS_ASSERT_NEXT(a_not_busy_after_reset, clk, rst, !busy)
  `GSTS_ASSERT_NEXT(a_done_single_cycle, clk, done, !done)
  `GSTS_ASSERT_NOW(a_done_needs_past_start, clk, rst, done && $past(rst), 1'b0)

endmodule

bind gaussian_source_term_sum gsts_checker u_gsts_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done)
);
